>>> sv/ckxb_pkg.sv
// shared types and constants for the chained key xor byte cipher
// no dependencies; imported by every module of the block

package ckxb_pkg;

	localparam int DATA_W     = 8;
	localparam int POS_W      = 5;
	localparam int LEN_W      = 6;
	localparam int KEY_WORDS  = 4;
	localparam int KEY_BYTES  = 32;
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	localparam logic [LEN_W-1:0] KEY_LEN_RESET = 6'd16;

	typedef logic [DATA_W-1:0] byte_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_KEY_LENGTH = 3'd1,
		REG_KEY_WORD_0 = 3'd2,
		REG_KEY_WORD_1 = 3'd3,
		REG_KEY_WORD_2 = 3'd4,
		REG_KEY_WORD_3 = 3'd5
	} reg_idx_t;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	typedef struct packed {
		logic                                  mode;
		logic [LEN_W-1:0]                      key_length;
		logic [KEY_WORDS-1:0][APB_DATA_W-1:0]  key_words;
	} cfg_t;

endpackage

>>> sv/ckxb_regs.sv
// apb configuration register file: mode, key length and four key words
// depends on ckxb_pkg

module ckxb_regs
	import ckxb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic                                 mode_q;
	logic [LEN_W-1:0]                     key_length_q;
	logic [KEY_WORDS-1:0][APB_DATA_W-1:0] key_words_q;
	logic [REG_IDX_W-1:0]                 idx;
	logic                                 wr_en;

	// 64-bit registers sit at 8-byte strides
	assign idx    = paddr[APB_ADDR_W-1:3];
	assign wr_en  = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ENCRYPT;
			key_length_q <= KEY_LEN_RESET;
			key_words_q  <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:       mode_q         <= pwdata[0];
				REG_KEY_LENGTH: key_length_q   <= pwdata[LEN_W-1:0];
				REG_KEY_WORD_0: key_words_q[0] <= pwdata;
				REG_KEY_WORD_1: key_words_q[1] <= pwdata;
				REG_KEY_WORD_2: key_words_q[2] <= pwdata;
				REG_KEY_WORD_3: key_words_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:       prdata = {{(APB_DATA_W-1){1'b0}}, mode_q};
			REG_KEY_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, key_length_q};
			REG_KEY_WORD_0: prdata = key_words_q[0];
			REG_KEY_WORD_1: prdata = key_words_q[1];
			REG_KEY_WORD_2: prdata = key_words_q[2];
			REG_KEY_WORD_3: prdata = key_words_q[3];
			default:        prdata = '0;
		endcase
	end

	assign cfg.mode       = mode_q;
	assign cfg.key_length = key_length_q;
	assign cfg.key_words  = key_words_q;

endmodule

>>> sv/ckxb_datapath.sv
// cipher datapath: chaining state registers and the per-byte transform
// depends on ckxb_pkg

module ckxb_datapath
	import ckxb_pkg::*;
#(
	parameter int MAX_KEY_BYTES = 32
)
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  step,
	input  logic  start,
	input  byte_t din,
	output byte_t dout
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_KEY_BYTES);

	logic [POS_W-1:0]             key_pos_q;
	byte_t                        prev_q;
	logic [LEN_W-1:0]             eff_len;
	logic [POS_W-1:0]             pos_cur;
	logic [POS_W-1:0]             pos_used;
	logic [LEN_W-1:0]             pos_inc;
	logic [POS_W-1:0]             pos_next;
	byte_t                        prev_cur;
	byte_t                        key;
	logic [KEY_BYTES-1:0][DATA_W-1:0] key_bytes;
	logic                         odd;
	byte_t                        mixed;
	byte_t                        result;
	byte_t                        plain;

	assign key_bytes = cfg.key_words;

	always_comb begin
		if (cfg.key_length == '0)
			eff_len = LEN_W'(1);
		else if (cfg.key_length > LEN_MAX)
			eff_len = LEN_MAX;
		else
			eff_len = cfg.key_length;
	end

	// start of string restarts the chain before this byte
	assign pos_cur  = start ? '0 : key_pos_q;
	assign prev_cur = start ? '0 : prev_q;
	// position left past a shortened key wraps
	assign pos_used = ({1'b0, pos_cur} >= eff_len) ? '0 : pos_cur;
	assign key      = key_bytes[pos_used];
	assign odd      = pos_used[0] & key[0];

	always_comb begin
		if (cfg.mode == MODE_ENCRYPT) begin
			mixed  = din ^ key;
			result = odd ? (((~mixed) + 8'd1) ^ key) + prev_cur : (~din) - prev_cur;
			plain  = din;
		end else begin
			mixed  = (din - prev_cur) ^ key;
			result = odd ? ((~mixed) + 8'd1) ^ key : ~(din + prev_cur);
			plain  = result;
		end
	end

	assign pos_inc  = {1'b0, pos_used} + LEN_W'(1);
	assign pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
			prev_q    <= '0;
		end else if (step) begin
			key_pos_q <= pos_next;
			prev_q    <= plain;
		end
	end

	assign dout = result;

endmodule

>>> sv/chained_key_xor_byte_cipher.sv
// chained key xor byte cipher: each beat passes the input stage and output registers,
// throughput one beat per cycle while m_axis_tready stays high; a stalled sink fills both stages
// the cipher transform sits between the input stage register and the output register;
// the chaining state (key position, previous plaintext) updates as the byte leaves stage one
// asynchronous active-low reset clears valids, chaining state and config to reset values
// depends on ckxb_pkg, ckxb_regs and ckxb_datapath

module chained_key_xor_byte_cipher
	import ckxb_pkg::*;
#(
	parameter int MAX_KEY_BYTES = 32
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tuser,   // [0] start_of_string
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata    // [7:0] result_byte
);

	cfg_t  cfg;
	logic  valid_s1;
	byte_t data_s1;
	logic  start_s1;
	logic  valid_s2;
	byte_t result_s2;
	logic  advance;
	logic  step;
	byte_t result;

	ckxb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// output slot is free or being drained this cycle
	assign advance       = !valid_s2 || m_axis_tready;
	// stage one hands its byte to the output register
	assign step          = valid_s1 && advance;
	// take a new beat whenever stage one is empty or moving on
	assign s_axis_tready = !valid_s1 || advance;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	ckxb_datapath #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.start  (start_s1),
		.din    (data_s1),
		.dout   (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

`ifndef SYNTH
	// input backpressure only when both stages hold a beat and the sink stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled without a full pipeline");

	// a byte stuck in stage one keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1) && $stable(start_s1)))
		else $error("stage one byte lost or changed while stalled");

	// every processed byte appears as a result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("processed byte did not reach the output register");
`endif

endmodule

>>> test/cipher_monitor.sv
// watches the apb port and both byte streams of chained_key_xor_byte_cipher and predicts each result
// keeps its own copy of the registers and chaining state; depends on ckxb_pkg

module cipher_monitor
	import ckxb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [DATA_W-1:0]     m_axis_tdata,
	output int                    failures,
	output int                    pending
);

	logic                  cfg_mode;
	logic [LEN_W-1:0]      cfg_key_length;
	logic [APB_DATA_W-1:0] cfg_key_words [KEY_WORDS];
	logic [POS_W-1:0]      key_pos;
	byte_t                 prev_plain;
	byte_t                 expected_bytes [$];
	byte_t                 want;

	initial failures = 0;
	initial pending = 0;

	function automatic byte_t next_cipher_byte(byte_t din, logic restart);
		int    len;
		int    pos;
		byte_t k;
		byte_t t;
		byte_t r;
		byte_t plain;
		logic  odd;
		len = cfg_key_length;
		if (len == 0) len = 1;
		if (len > KEY_BYTES) len = KEY_BYTES;
		if (restart) begin
			key_pos = '0;
			prev_plain = '0;
		end
		pos = key_pos;
		if (pos >= len) pos = 0;
		k = cfg_key_words[pos / 8][(pos % 8) * 8 +: 8];
		odd = (pos % 2 == 1) && k[0];
		if (cfg_mode == MODE_ENCRYPT) begin
			plain = din;
			if (odd) begin
				t = din ^ k;
				t = -t;
				t = t ^ k;
				r = t + prev_plain;
			end else begin
				t = ~din;
				r = t - prev_plain;
			end
		end else begin
			if (odd) begin
				t = din - prev_plain;
				t = t ^ k;
				t = -t;
				r = t ^ k;
			end else begin
				t = din + prev_plain;
				r = ~t;
			end
			plain = r;
		end
		prev_plain = plain;
		pos++;
		if (pos >= len) pos = 0;
		key_pos = POS_W'(pos);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode = MODE_ENCRYPT;
			cfg_key_length = KEY_LEN_RESET;
			foreach (cfg_key_words[i]) cfg_key_words[i] = '0;
			key_pos = '0;
			prev_plain = '0;
			expected_bytes.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_ADDR_W-1:3])
					REG_MODE:       cfg_mode = pwdata[0];
					REG_KEY_LENGTH: cfg_key_length = pwdata[LEN_W-1:0];
					REG_KEY_WORD_0: cfg_key_words[0] = pwdata;
					REG_KEY_WORD_1: cfg_key_words[1] = pwdata;
					REG_KEY_WORD_2: cfg_key_words[2] = pwdata;
					REG_KEY_WORD_3: cfg_key_words[3] = pwdata;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_bytes.insert(expected_bytes.size(),
					next_cipher_byte(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("result_byte: expected nothing, actual %02h", m_axis_tdata);
					failures++;
				end else begin
					want = expected_bytes.pop_front();
					if (want !== m_axis_tdata) begin
						$error("result_byte: expected %02h, actual %02h", want, m_axis_tdata);
						failures++;
					end
				end
			end
		end
		pending = expected_bytes.size();
	end

endmodule

>>> test/testbench.sv
// stimulus and verdict for chained_key_xor_byte_cipher: directed corner bytes, then random strings
// under random stalls and register settings; depends on ckxb_pkg, the block and cipher_monitor

module testbench
	import ckxb_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 200;
	localparam int TARGET_BYTES   = 1350;
	localparam int IDLE_PERCENT   = 21;
	// no register decodes here, so writes to it must change nothing
	localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = 6'd48;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata;   // [7:0] data_byte
	logic                  s_axis_tuser;   // [0] start_of_string
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DATA_W-1:0]     m_axis_tdata;   // [7:0] result_byte

	int failures;
	int pending;
	int sent;
	int stuck_cycles;
	bit idle_on;
	bit hold_request;

	chained_key_xor_byte_cipher dut (.*);

	cipher_monitor mon (.*);

	// free-running clock, period 10
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any beat or apb access counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (psel && penable && pready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// result side: random back-pressure, or a long hold-off when asked for
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	function automatic logic [APB_ADDR_W-1:0] addr_of(reg_idx_t idx);
		return {idx, 3'b000};
	endfunction

	// setup cycle, then access cycle; register lands on the edge with pready high
	task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one input beat; tvalid stays up after the handshake so back-to-back beats need no gap
	task automatic send_beat(byte_t value, logic restart);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= restart;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// stop offering and wait for every predicted result; the count is stable at the falling edge
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// a well-formed string opens with the start flag; a broken one draws the flag at random on
	// every byte, the first included, and so scatters restarts through the middle
	task automatic send_string(int len, bit broken);
		logic restart;
		for (int i = 0; i < len; i++) begin
			restart = broken ? ($urandom_range(5) == 0) : (i == 0);
			send_beat(byte_t'($urandom_range(255)), restart);
		end
	endtask

	task automatic random_config();
		logic [LEN_W-1:0] len;
		int               pick;
		pick = $urandom_range(9);
		case (pick)
			0:       len = 6'd0;
			1:       len = 6'd1;
			2:       len = 6'd32;
			3:       len = 6'd33;
			4:       len = 6'd63;
			default: len = LEN_W'($urandom_range(2, 31));
		endcase
		apb_write(addr_of(REG_MODE), APB_DATA_W'($urandom_range(1)));
		apb_write(addr_of(REG_KEY_LENGTH), APB_DATA_W'(len));
		apb_write(addr_of(REG_KEY_WORD_0), {$urandom, $urandom});
		apb_write(addr_of(REG_KEY_WORD_1), {$urandom, $urandom});
		apb_write(addr_of(REG_KEY_WORD_2), {$urandom, $urandom});
		apb_write(addr_of(REG_KEY_WORD_3), {$urandom, $urandom});
		if ($urandom_range(3) == 0)
			apb_write(UNUSED_ADDR, {$urandom, $urandom});
	endtask

	initial begin
		int phase;
		int strings;
		arst_n = 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		sent = 0;
		stuck_cycles = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero key, so only the plain complement branch
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h01, 1'b0);

		// all-odd low key bytes, oversized length acting as the full key
		wait_drained();
		apb_write(addr_of(REG_KEY_WORD_0), 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(addr_of(REG_KEY_WORD_1), 64'h0000_0000_0000_0000);
		apb_write(addr_of(REG_KEY_WORD_2), 64'hA5A5_A5A5_A5A5_A5A5);
		apb_write(addr_of(REG_KEY_WORD_3), 64'h5A5A_5A5A_5A5A_5A5A);
		apb_write(addr_of(REG_KEY_LENGTH), 64'd63);
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(8'h80, 1'b0);
		send_beat(8'h55, 1'b0);
		send_beat(8'hAA, 1'b0);

		// decrypt with zero length: behaves as length one, position stays even
		wait_drained();
		apb_write(addr_of(REG_MODE), APB_DATA_W'(MODE_DECRYPT));
		apb_write(addr_of(REG_KEY_LENGTH), 64'd0);
		send_beat(8'hFF, 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat(8'h3C, 1'b0);

		// decrypt through the odd branch; the unused address must not disturb anything
		wait_drained();
		apb_write(addr_of(REG_KEY_LENGTH), 64'd2);
		apb_write(UNUSED_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
		send_beat(8'h12, 1'b1);
		send_beat(8'hFE, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(8'hC3, 1'b0);

		// length just past the key size, then shrink it mid-string so the
		// stored position lies beyond the new length and must wrap
		wait_drained();
		apb_write(addr_of(REG_MODE), APB_DATA_W'(MODE_ENCRYPT));
		apb_write(addr_of(REG_KEY_LENGTH), 64'd33);
		send_beat(8'h10, 1'b1);
		send_beat(8'hEF, 1'b0);
		send_beat(8'h33, 1'b0);
		send_beat(8'hCC, 1'b0);
		send_beat(8'h01, 1'b0);
		send_beat(8'hFE, 1'b0);
		wait_drained();
		apb_write(addr_of(REG_KEY_LENGTH), 64'd1);
		send_beat(8'h44, 1'b0);
		send_beat(8'hBB, 1'b0);

		// random part: strings under changing settings, each phase drained first
		phase = 0;
		while (sent < TARGET_BYTES) begin
			phase++;
			wait_drained();
			if (phase % 3 == 1)
				random_config();
			// one long stretch with no idling on either side
			idle_on = (phase != 4);
			// receiver stalls long enough for the block to back up into the sender
			if (phase == 2 || phase == 6)
				hold_request = 1'b1;
			strings = (phase == 4) ? 12 : $urandom_range(2, 6);
			repeat (strings)
				send_string($urandom_range(1, 70), $urandom_range(7) == 0);
		end
		idle_on = 1'b1;

		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
